@@ rtl/core/rrps_pkg.sv @@
`timescale 1ns / 1ps

package rrps_pkg;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int DEV_W   = 5;
  localparam int CNT_W   = 4;
  localparam int MASK_W  = 32;
  localparam int LIMIT_W = 4;

  // Device count range
  localparam int DEVICE_COUNT_DEF = 32;
  localparam int DEVICE_COUNT_MAX = 64;

  // APB register map
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_SELECT_MASK    = 2'd0,
    REG_RETRY_INTERVAL = 2'd1,
    REG_RETRY_LIMIT    = 2'd2
  } reg_idx_t;

  // Register reset values
  localparam logic [MASK_W-1:0]  SELECT_MASK_RST    = '0;
  localparam logic [TIME_W-1:0]  RETRY_INTERVAL_RST = 32'd1000;
  localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST    = 4'd3;

  // Input item kinds
  typedef enum logic {
    KIND_POLL  = 1'b0,
    KIND_REPLY = 1'b1
  } kind_t;

  // Result packing in m_tdata
  localparam int OUT_W = 8;

endpackage

@@ rtl/core/rrps_pick.sv @@
`timescale 1ns / 1ps

// Next selected device at or above the start index (round-robin search).
module rrps_pick #(
  parameter int DEVICE_COUNT = rrps_pkg::DEVICE_COUNT_DEF
) (
  input  logic [rrps_pkg::MASK_W-1:0]          select_mask,
  input  logic [$clog2(DEVICE_COUNT+1)-1:0]    start,
  output logic                                 found,
  output logic [((DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1)-1:0] idx
);

  localparam int NXT_W = $clog2(DEVICE_COUNT + 1);
  localparam int IDX_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam int EXT_W = rrps_pkg::DEVICE_COUNT_MAX;

  logic [EXT_W-1:0] mask_ext;
  logic [NXT_W-1:0] start_eff;

  // devices above the mask width are never selected
  assign mask_ext  = EXT_W'(select_mask);
  // out-of-range start wraps to zero
  assign start_eff = (start >= NXT_W'(DEVICE_COUNT)) ? '0 : start;

  always_comb begin
    found = 1'b0;
    idx   = '0;
    // lowest hit wins
    for (int i = DEVICE_COUNT - 1; i >= 0; i--) begin
      if (mask_ext[i] && (NXT_W'(i) >= start_eff)) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

endmodule

@@ rtl/core/round_robin_poll_retry_scheduler_unit.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tuser: kind, s_tdata: now_time
// m_*       out  m_tvalid/m_tready   m_tdata: issue_query, device_index, comm_alarm
// apb       in   psel/penable/pwrite select_mask @0x0, retry_interval @0x4, retry_limit @0x8
//
// One input transaction per cycle while s_tready is high, one result transaction per input,
// registered in the cycle after it is accepted. Retry counters live in a RAM with a registered
// read; the read address is the device being awaited, taken from next state so data is ready for the next transaction.
// A write to the same entry in the previous cycle is forwarded around the RAM.
// Reset clears control state and per-entry valid bits (invalid entry reads zero).
// The output register decouples stalls: s_tready holds while m_tready is low
// only if the output register is empty.
module round_robin_poll_retry_scheduler_unit #(
  parameter int DEVICE_COUNT = rrps_pkg::DEVICE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rrps_pkg::TIME_W-1:0]       s_tdata,   // [31:0] now_time
  input  logic                              s_tuser,   // [0] kind
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rrps_pkg::OUT_W-1:0]        m_tdata,   // [0] issue_query, [5:1] device_index,
                                                       // [6] comm_alarm, [7] zero
  // APB config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rrps_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rrps_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rrps_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int NXT_W = $clog2(DEVICE_COUNT + 1);
  localparam int IDX_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam int TIME_W = rrps_pkg::TIME_W;
  localparam int DEV_W  = rrps_pkg::DEV_W;
  localparam int CNT_W  = rrps_pkg::CNT_W;

  // ---------------- configuration registers ----------------
  logic [rrps_pkg::MASK_W-1:0]  select_mask;
  logic [TIME_W-1:0]            retry_interval;
  logic [rrps_pkg::LIMIT_W-1:0] retry_limit;
  rrps_pkg::reg_idx_t           reg_sel;
  logic                         cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = rrps_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      select_mask    <= rrps_pkg::SELECT_MASK_RST;
      retry_interval <= rrps_pkg::RETRY_INTERVAL_RST;
      retry_limit    <= rrps_pkg::RETRY_LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        rrps_pkg::REG_SELECT_MASK:    select_mask    <= pwdata;
        rrps_pkg::REG_RETRY_INTERVAL: retry_interval <= pwdata;
        rrps_pkg::REG_RETRY_LIMIT:    retry_limit    <= pwdata[rrps_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rrps_pkg::REG_SELECT_MASK:    prdata = select_mask;
      rrps_pkg::REG_RETRY_INTERVAL: prdata = retry_interval;
      rrps_pkg::REG_RETRY_LIMIT:    prdata = rrps_pkg::APB_DATA_W'(retry_limit);
      default:                      prdata = '0;
    endcase
  end

  // ---------------- scheduler state ----------------
  logic [NXT_W-1:0]  next_index, next_index_next;
  logic [IDX_W-1:0]  cur_dev, cur_dev_next;     // device awaited (next_index - 1)
  logic              awaiting, awaiting_next;
  logic [TIME_W-1:0] last_send_time, last_send_time_next;

  // retry counter RAM with valid bits and write forwarding
  logic [CNT_W-1:0]  cnt_mem [DEVICE_COUNT];
  logic [DEVICE_COUNT-1:0] cnt_vld;
  logic [CNT_W-1:0]  rd_cnt;
  logic              rd_vld;
  logic              byp_hit;
  logic [CNT_W-1:0]  byp_cnt;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;

  logic              acc;
  rrps_pkg::kind_t   kind;
  logic [TIME_W-1:0] now_time;
  logic [TIME_W-1:0] elapsed;
  logic              timeout;
  logic [CNT_W-1:0]  count_cur, count_inc;
  logic              pick_found;
  logic [IDX_W-1:0]  pick_idx;
  logic [IDX_W+DEV_W-1:0] pick_ext, cur_ext;

  logic              issue_query;
  logic [DEV_W-1:0]  device_index;
  logic              comm_alarm;

  assign acc       = s_tvalid && s_tready;
  assign kind      = rrps_pkg::kind_t'(s_tuser);
  assign now_time  = s_tdata;
  assign s_tready  = !m_tvalid || m_tready;

  assign elapsed   = now_time - last_send_time;   // wraps modulo 2^32
  assign timeout   = elapsed >= retry_interval;
  assign count_cur = byp_hit ? byp_cnt : (rd_vld ? rd_cnt : '0);
  assign count_inc = count_cur + CNT_W'(1);
  assign pick_ext  = (IDX_W + DEV_W)'(pick_idx);
  assign cur_ext   = (IDX_W + DEV_W)'(cur_dev);

  rrps_pick #(
    .DEVICE_COUNT(DEVICE_COUNT)
  ) u_pick (
    .select_mask(select_mask),
    .start      (next_index),
    .found      (pick_found),
    .idx        (pick_idx)
  );

  always_comb begin
    next_index_next     = next_index;
    cur_dev_next        = cur_dev;
    awaiting_next       = awaiting;
    last_send_time_next = last_send_time;
    issue_query         = 1'b0;
    device_index        = '0;
    comm_alarm          = 1'b0;
    mem_we              = 1'b0;
    mem_waddr           = cur_dev;
    mem_wdata           = count_inc;
    if (acc) begin
      if (kind == rrps_pkg::KIND_REPLY) begin
        awaiting_next = 1'b0;
      end else if (awaiting) begin
        if (timeout) begin
          // re-query the awaited device
          last_send_time_next = now_time;
          issue_query         = 1'b1;
          device_index        = cur_ext[DEV_W-1:0];
          mem_we              = 1'b1;
          if (count_inc >= retry_limit) begin
            awaiting_next = 1'b0;
            comm_alarm    = 1'b1;
            mem_wdata     = '0;
          end
        end
      end else if (pick_found) begin
        next_index_next     = NXT_W'(pick_idx) + NXT_W'(1);
        cur_dev_next        = pick_idx;
        last_send_time_next = now_time;
        awaiting_next       = 1'b1;
        issue_query         = 1'b1;
        device_index        = pick_ext[DEV_W-1:0];
      end else begin
        next_index_next = '0;
      end
    end
  end

  // read the entry of the device that will be awaited next cycle
  assign rd_addr = cur_dev_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_index     <= '0;
      cur_dev        <= '0;
      awaiting       <= 1'b0;
      last_send_time <= '0;
    end else begin
      next_index     <= next_index_next;
      cur_dev        <= cur_dev_next;
      awaiting       <= awaiting_next;
      last_send_time <= last_send_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_waddr] <= mem_wdata;
    end
    rd_cnt <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
      rd_vld  <= 1'b0;
      byp_hit <= 1'b1;     // entry zero reads as cleared right after reset
      byp_cnt <= '0;
    end else begin
      if (mem_we) begin
        cnt_vld[mem_waddr] <= 1'b1;
      end
      rd_vld  <= cnt_vld[rd_addr];
      byp_hit <= mem_we && (mem_waddr == rd_addr);
      byp_cnt <= mem_wdata;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      m_tdata <= {1'b0, comm_alarm, device_index, issue_query};
    end
  end

  // ---------------- assertions ----------------
  a_reply_clears_wait: assert property (@(posedge clk) disable iff (rst)
    (acc && kind == rrps_pkg::KIND_REPLY) |=> !awaiting)
    else $error("reply did not clear the wait");

  a_wait_tracks_index: assert property (@(posedge clk) disable iff (rst)
    awaiting |-> (next_index == NXT_W'(cur_dev) + NXT_W'(1)))
    else $error("awaited device out of step with next index");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    acc |=> m_tvalid)
    else $error("accepted transaction produced no result");

endmodule
